// File: sv/sect_pkg.sv
// shared types, codes and constants of the screen edge crossing tracker
package sect_pkg;

	// default geometry of the coordinate and travel registers
	localparam int COORD_BITS_DEF  = 14;
	localparam int TRAVEL_BITS_DEF = 21;

	// fixed field widths
	localparam int SIZE_W    = 15;
	localparam int RATIO_W   = 16;
	localparam int TGT_W     = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 15;

	// behavior constants
	localparam int RETURN_LIMIT = 150;
	localparam int HOME_OFFSET  = 2;
	localparam int RATIO_MID    = 32768;
	localparam int RATIO_MAX    = 65535;

	// register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGES  = 2'd2;
	localparam logic [SIZE_W-1:0]    WIDTH_RST  = 15'd1920;
	localparam logic [SIZE_W-1:0]    HEIGHT_RST = 15'd1080;
	localparam logic [7:0]           EDGES_RST  = 8'd0;

	// request commands
	localparam logic [1:0] CMD_POS     = 2'd0;
	localparam logic [1:0] CMD_DELTA   = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;

	// event kinds
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_ENTER   = 3'd1;
	localparam logic [2:0] EV_FWD     = 3'd2;
	localparam logic [2:0] EV_RETURN  = 3'd3;
	localparam logic [2:0] EV_RELEASE = 3'd4;

	// edge codes
	localparam logic [2:0] EDGE_LEFT   = 3'd0;
	localparam logic [2:0] EDGE_RIGHT  = 3'd1;
	localparam logic [2:0] EDGE_TOP    = 3'd2;
	localparam logic [2:0] EDGE_BOTTOM = 3'd3;
	localparam logic [2:0] EDGE_TL     = 3'd4;
	localparam logic [2:0] EDGE_TR     = 3'd5;
	localparam logic [2:0] EDGE_BL     = 3'd6;
	localparam logic [2:0] EDGE_BR     = 3'd7;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
	} sect_in_t;

	typedef struct packed {
		logic [2:0]         event_kind;
		logic [2:0]         edge_code;
		logic [RATIO_W-1:0] x_ratio;
		logic [RATIO_W-1:0] y_ratio;
		logic [TGT_W-1:0]   target_x;
		logic [TGT_W-1:0]   target_y;
		logic signed [15:0] fwd_dx;
		logic signed [15:0] fwd_dy;
	} sect_out_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} sect_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic load_direct;
		logic div_start;
		logic div_step;
		logic div_finish;
	} sect_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic entry;
	} sect_sts_t;

endpackage

// File: sv/sect_in_if.sv
// request channel carrying position samples, deltas and release commands
interface sect_in_if;
	import sect_pkg::*;

	logic     valid;
	logic     ready;
	sect_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/sect_out_if.sv
// result channel carrying one event per request
interface sect_out_if;
	import sect_pkg::*;

	logic      valid;
	logic      ready;
	sect_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/screen_edge_crossing_tracker.sv
// top level of the screen edge crossing tracker
//
//   channel   dir  handshake      contents
//   in_ch     in   valid/ready    cmd, pos_x, pos_y, delta_x, delta_y
//   out_ch    out  valid/ready    event_kind, edge_code, ratios, targets, deltas
//   cfg_*     in   write enable   screen_width, screen_height, edge_enable
//
// a request that does not enter capture has its event registered at
// acceptance; a new request can be taken in the next cycle
// an entering request runs the two 16-step ratio divider lanes side by side;
// no request is taken while they run
// a pending result holds in the output register; a request is still taken
// in the cycle that register is being emptied
// reset clears config to its defaults, the tracking state and the valid
module screen_edge_crossing_tracker #(
	parameter int COORD_BITS  = sect_pkg::COORD_BITS_DEF,
	parameter int TRAVEL_BITS = sect_pkg::TRAVEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sect_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sect_pkg::CFG_DAT_W-1:0] cfg_wdata,
	sect_in_if.sink                        in_ch,
	sect_out_if.source                     out_ch
);
	import sect_pkg::*;

	sect_cmd_t cmd;
	sect_sts_t sts;

	// sequencing: acceptance, divide count, output valid
	sect_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	// config, tracking state, edge tests, motion and ratio math
	sect_dp #(
		.COORD_BITS  (COORD_BITS),
		.TRAVEL_BITS (TRAVEL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (in_ch.data),
		.cmd       (cmd),
		.sts       (sts),
		.res       (out_ch.data)
	);

	// a request is only taken when the output register is free or draining
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (!out_ch.valid || out_ch.ready))
		else $error("request taken while result register stays full");

	// divider steps block new requests
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !in_ch.ready)
		else $error("request taken during ratio division");

	// an entry leaves the output register empty until the division ends
	a_entry_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !out_ch.valid)
		else $error("result shown before entry ratios were ready");

	// finishing the division presents an entry event
	a_entry_event: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_finish |=> (out_ch.valid && out_ch.data.event_kind == EV_ENTER))
		else $error("division finished without an entry event");
endmodule

// File: sv/sect_div.sv
// restoring divider lane, one quotient bit per step
module sect_div (
	input  logic                         clk,
	input  logic                         start,
	input  logic                         step,
	input  logic [sect_pkg::SIZE_W-1:0]  num,
	input  logic [sect_pkg::SIZE_W-1:0]  den,
	output logic [sect_pkg::RATIO_W-1:0] quo_nxt
);
	import sect_pkg::*;

	logic [SIZE_W-1:0]  rem_q;
	logic [SIZE_W-1:0]  den_q;
	logic [RATIO_W-1:0] quo_q;
	logic [SIZE_W:0]    rem2;
	logic [SIZE_W:0]    diff;
	logic               ge;
	logic [SIZE_W-1:0]  rem_nxt;

	// remainder stays below the divisor, so doubling fits one extra bit
	assign rem2    = {rem_q, 1'b0};
	assign diff    = rem2 - {1'b0, den_q};
	assign ge      = rem2 >= {1'b0, den_q};
	assign rem_nxt = ge ? diff[SIZE_W-1:0] : rem2[SIZE_W-1:0];
	assign quo_nxt = {quo_q[RATIO_W-2:0], ge};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (step) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end
endmodule

// File: sv/sect_ctrl.sv
// controller: request acceptance, divide sequencing and result valid
module sect_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  out_ready,
	input  sect_pkg::sect_sts_t   sts,
	output logic                  in_ready,
	output logic                  out_valid,
	output sect_pkg::sect_cmd_t   cmd
);
	import sect_pkg::*;

	localparam int CNT_W = $clog2(RATIO_W);

	sect_state_t      state_q;
	sect_state_t      state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             div_last;
	logic             take;

	assign div_last  = cnt_q == CNT_W'(RATIO_W - 1);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && sts.entry) state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (div_last) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		take     = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready        = !out_valid_q || out_ready;
				take            = in_valid && in_ready;
				cmd.take        = take;
				cmd.load_direct = take && !sts.entry;
				cmd.div_start   = take && sts.entry;
			end
			ST_DIV: begin
				cmd.div_step   = 1'b1;
				cmd.div_finish = div_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.div_start) cnt_q <= '0;
			else if (cmd.div_step) cnt_q <= cnt_q + 1'b1;
			if (cmd.load_direct || cmd.div_finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

// File: sv/sect_dp.sv
// datapath: config, tracking state, edge test, motion update, ratio lanes, result register
module sect_dp #(
	parameter int COORD_BITS  = sect_pkg::COORD_BITS_DEF,
	parameter int TRAVEL_BITS = sect_pkg::TRAVEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sect_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sect_pkg::CFG_DAT_W-1:0] cfg_wdata,
	input  sect_pkg::sect_in_t             req,
	input  sect_pkg::sect_cmd_t            cmd,
	output sect_pkg::sect_sts_t            sts,
	output sect_pkg::sect_out_t            res
);
	import sect_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int TB = TRAVEL_BITS;
	localparam int SW = ((TB > 16) ? TB : 16) + 1;
	localparam int CMAX = (1 << CB) - 1;
	localparam logic signed [SW-1:0] TR_MAX = {{(SW-TB+1){1'b0}}, {(TB-1){1'b1}}};
	localparam logic signed [SW-1:0] TR_MIN = ~TR_MAX;
	localparam logic signed [SW-1:0] RET_POS = SW'(RETURN_LIMIT);
	localparam logic signed [SW-1:0] RET_NEG = -RET_POS;

	// size minus offset, floored at 0 and capped at the coordinate range
	function automatic logic [CB-1:0] limit_of(input logic [SIZE_W-1:0] size,
			input logic [1:0] minus);
		logic signed [SIZE_W+1:0] d;
		logic signed [SIZE_W+1:0] cap;
		d   = $signed({2'b00, size}) - $signed({{SIZE_W{1'b0}}, minus});
		cap = (SIZE_W+2)'(CMAX);
		if (d < 0) return '0;
		else if (d > cap) return cap[CB-1:0];
		else return d[CB-1:0];
	endfunction

	function automatic logic [CB-1:0] clamp_to(input logic signed [17:0] v,
			input logic [CB-1:0] lim);
		if (v < 0) return '0;
		else if (v > $signed(18'(lim))) return lim;
		else return v[CB-1:0];
	endfunction

	function automatic logic [TB-1:0] sat_travel(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] r;
		if (s > TR_MAX) r = TR_MAX;
		else if (s < TR_MIN) r = TR_MIN;
		else r = s;
		return r[TB-1:0];
	endfunction

	function automatic logic [TGT_W-1:0] to_tgt(input logic [CB-1:0] a);
		logic [31:0] t;
		t = 32'(a);
		return t[TGT_W-1:0];
	endfunction

	// {use divider, fixed ratio}
	function automatic logic [RATIO_W:0] ratio_fix(input logic signed [15:0] pos,
			input logic [SIZE_W-1:0] size);
		if (size == '0) return {1'b0, RATIO_W'(RATIO_MID)};
		else if (pos <= 0) return '0;
		else if (pos >= $signed({1'b0, size})) return {1'b0, RATIO_W'(RATIO_MAX)};
		else return {1'b1, {RATIO_W{1'b0}}};
	endfunction

	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;
	logic [7:0]         edges_q;
	logic               captured_q;
	logic [2:0]         active_edge_q;
	logic [CB-1:0]      vx_q;
	logic [CB-1:0]      vy_q;
	logic [TB-1:0]      trx_q;
	logic [TB-1:0]      try_q;
	logic [RATIO_W:0]   xfix_q;
	logic [RATIO_W:0]   yfix_q;
	sect_out_t          res_q;

	logic [CB-1:0]      lim_w1, lim_h1, lim_w2, lim_h2;
	logic signed [16:0] xe, ye, we, he;
	logic               x_lo, x_hi, x_in, y_lo, y_hi, y_in;
	logic [7:0]         hit;
	logic [7:0]         sel;
	logic [2:0]         entry_edge;
	logic               entry;
	logic [CB-1:0]      ent_vx, ent_vy;
	logic               moved;
	logic               release_hit;
	logic [CB-1:0]      mv_vx, mv_vy;
	logic signed [SW-1:0] sum_x, sum_y, sat_x, sat_y;
	logic [TB-1:0]      mv_trx, mv_try;
	logic               back;
	logic [TGT_W-1:0]   tgt_a, tgt_b;
	sect_out_t          direct;
	sect_out_t          enter_res;
	logic [RATIO_W-1:0] quo_x, quo_y;

	assign lim_w1 = limit_of(width_q, 2'd1);
	assign lim_h1 = limit_of(height_q, 2'd1);
	assign lim_w2 = limit_of(width_q, 2'(HOME_OFFSET));
	assign lim_h2 = limit_of(height_q, 2'(HOME_OFFSET));

	// edge test on the sample
	assign xe   = {req.pos_x[15], req.pos_x};
	assign ye   = {req.pos_y[15], req.pos_y};
	assign we   = $signed({2'b00, width_q});
	assign he   = $signed({2'b00, height_q});
	assign x_lo = xe <= 0;
	assign x_hi = xe >= we;
	assign x_in = (xe > 0) && (xe < we);
	assign y_lo = ye <= 0;
	assign y_hi = ye >= he;
	assign y_in = (ye > 0) && (ye < he);

	always_comb begin
		hit              = '0;
		hit[EDGE_LEFT]   = x_lo && y_in;
		hit[EDGE_RIGHT]  = x_hi && y_in;
		hit[EDGE_TOP]    = y_lo && x_in;
		hit[EDGE_BOTTOM] = y_hi && x_in;
		hit[EDGE_TL]     = x_lo && y_lo;
		hit[EDGE_TR]     = x_hi && y_lo;
		hit[EDGE_BL]     = x_lo && y_hi;
		hit[EDGE_BR]     = x_hi && y_hi;
	end

	assign sel = hit & edges_q;

	// lowest enabled code wins
	always_comb begin
		entry_edge = '0;
		for (int e = 7; e >= 0; e--) begin
			if (sel[e]) entry_edge = 3'(e);
		end
	end

	assign entry  = (req.cmd == CMD_POS) && !captured_q && (sel != '0);
	assign ent_vx = clamp_to({{2{req.pos_x[15]}}, req.pos_x}, lim_w1);
	assign ent_vy = clamp_to({{2{req.pos_y[15]}}, req.pos_y}, lim_h1);
	assign sts.entry = entry;

	// motion update
	assign moved = (req.cmd == CMD_DELTA) && captured_q &&
		((req.delta_x != '0) || (req.delta_y != '0));
	assign release_hit = (req.cmd == CMD_RELEASE) && captured_q;

	assign mv_vx = clamp_to($signed({{(18-CB){1'b0}}, vx_q}) +
		$signed({{2{req.delta_x[15]}}, req.delta_x}), lim_w1);
	assign mv_vy = clamp_to($signed({{(18-CB){1'b0}}, vy_q}) +
		$signed({{2{req.delta_y[15]}}, req.delta_y}), lim_h1);

	assign sum_x = $signed({{(SW-TB){trx_q[TB-1]}}, trx_q}) +
		$signed({{(SW-16){req.delta_x[15]}}, req.delta_x});
	assign sum_y = $signed({{(SW-TB){try_q[TB-1]}}, try_q}) +
		$signed({{(SW-16){req.delta_y[15]}}, req.delta_y});
	assign mv_trx = sat_travel(sum_x);
	assign mv_try = sat_travel(sum_y);
	assign sat_x  = $signed({{(SW-TB){mv_trx[TB-1]}}, mv_trx});
	assign sat_y  = $signed({{(SW-TB){mv_try[TB-1]}}, mv_try});

	always_comb begin
		case (active_edge_q) inside
			EDGE_LEFT, EDGE_TL, EDGE_BL: begin
				back  = sat_x > RET_POS;
				tgt_a = TGT_W'(HOME_OFFSET);
				tgt_b = to_tgt(mv_vy);
			end
			EDGE_RIGHT, EDGE_TR, EDGE_BR: begin
				back  = sat_x < RET_NEG;
				tgt_a = to_tgt(lim_w2);
				tgt_b = to_tgt(mv_vy);
			end
			EDGE_TOP: begin
				back  = sat_y > RET_POS;
				tgt_a = to_tgt(mv_vx);
				tgt_b = to_tgt(lim_h2);
			end
			default: begin
				back  = sat_y < RET_NEG;
				tgt_a = to_tgt(mv_vx);
				tgt_b = TGT_W'(HOME_OFFSET);
			end
		endcase
	end

	// results that need no division
	always_comb begin
		direct = '0;
		if (moved) begin
			direct.event_kind = back ? EV_RETURN : EV_FWD;
			direct.edge_code  = active_edge_q;
			direct.fwd_dx     = req.delta_x;
			direct.fwd_dy     = req.delta_y;
			if (back) begin
				direct.target_x = tgt_a;
				direct.target_y = tgt_b;
			end
		end else if (release_hit) begin
			direct.event_kind = EV_RELEASE;
			direct.edge_code  = active_edge_q;
		end
	end

	// entry event once both ratio lanes are done
	always_comb begin
		enter_res            = '0;
		enter_res.event_kind = EV_ENTER;
		enter_res.edge_code  = active_edge_q;
		enter_res.x_ratio    = xfix_q[RATIO_W] ? quo_x : xfix_q[RATIO_W-1:0];
		enter_res.y_ratio    = yfix_q[RATIO_W] ? quo_y : yfix_q[RATIO_W-1:0];
	end

	sect_div u_div_x (
		.clk     (clk),
		.start   (cmd.div_start),
		.step    (cmd.div_step),
		.num     (req.pos_x[SIZE_W-1:0]),
		.den     (width_q),
		.quo_nxt (quo_x)
	);

	sect_div u_div_y (
		.clk     (clk),
		.start   (cmd.div_start),
		.step    (cmd.div_step),
		.num     (req.pos_y[SIZE_W-1:0]),
		.den     (height_q),
		.quo_nxt (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q       <= WIDTH_RST;
			height_q      <= HEIGHT_RST;
			edges_q       <= EDGES_RST;
			captured_q    <= 1'b0;
			active_edge_q <= '0;
			vx_q          <= '0;
			vy_q          <= '0;
			trx_q         <= '0;
			try_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_WIDTH:  width_q  <= cfg_wdata[SIZE_W-1:0];
					REG_HEIGHT: height_q <= cfg_wdata[SIZE_W-1:0];
					REG_EDGES:  edges_q  <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (cmd.take) begin
				if (entry) begin
					captured_q    <= 1'b1;
					active_edge_q <= entry_edge;
					vx_q          <= ent_vx;
					vy_q          <= ent_vy;
					trx_q         <= '0;
					try_q         <= '0;
				end else if (moved) begin
					vx_q  <= mv_vx;
					vy_q  <= mv_vy;
					trx_q <= mv_trx;
					try_q <= mv_try;
					if (back) captured_q <= 1'b0;
				end else if (release_hit) begin
					captured_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			xfix_q <= ratio_fix(req.pos_x, width_q);
			yfix_q <= ratio_fix(req.pos_y, height_q);
		end
		if (cmd.load_direct) begin
			res_q <= direct;
		end else if (cmd.div_finish) begin
			res_q <= enter_res;
		end
	end

	assign res = res_q;
endmodule
